FILE: hdl/assert_macros.svh
// Assertion helpers used by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dthf_pkg.sv
// ----------------------------------------------------------------------------
// dthf_pkg
// Types and constants for the hex floating-point text formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package dthf_pkg;

  localparam logic [3:0]  FRAC_NIBBLES  = 4'd13;
  localparam logic [3:0]  PREC_RESET    = 4'd13;
  localparam logic [10:0] EXP_BIAS      = 11'd1023;
  localparam logic [7:0]  RECIP10       = 8'd205;
  localparam logic [4:0]  MAX_CHAR_IDX  = 5'd23;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_LOWA  = 8'h61;

  typedef struct packed {
    logic        neg;
    logic [3:0]  prec;
    logic [3:0]  lead;
    logic [51:0] frac;
    logic        eneg;
    logic [6:0]  q1;
    logic [3:0]  r0;
  } fmt_rec_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = CH_ZERO + {4'd0, nib};
    else c = CH_LOWA + {4'd0, nib - 4'd10};
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/double_to_hex_float_text.sv
// ----------------------------------------------------------------------------
// double_to_hex_float_text
// Formats a binary64 pattern as %a style hex text, one ASCII character per
// output word.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  cfg     | cfg_valid / cfg_ready | cfg_data[3:0] (precision)
//  in      | in_valid / in_ready   | value_bits[63:0]
//  out     | out_valid / out_ready | char_code[7:0], last
//
//  One input word yields 6 to 24 output words, one per cycle when out_ready
//  stays high, set by the character emitter; the next input word is held
//  in the input register meanwhile, so values follow with no gap.
//  A first character passes the input, record and output registers in turn.
//  rst (synchronous) empties all stages and sets precision to 13.
//  A low out_ready holds the output word and stalls the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module double_to_hex_float_text (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] value_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       char_code,
  output logic             last
);

  `include "assert_macros.svh"

  logic [3:0]  precision;
  logic        a_valid;
  logic [63:0] a_bits;
  logic        b_valid;
  logic [4:0]  b_idx;
  dthf_pkg::fmt_rec_t b_rec;
  dthf_pkg::fmt_rec_t rec_next;

  logic        emit;
  logic        a_take;
  logic [7:0]  ch;
  logic        ch_last;

  assign cfg_ready = 1'b1;

  // Format front end
  logic [3:0]  p;
  logic [52:0] mant;
  logic [5:0]  sh;
  logic [52:0] kept0;
  logic [52:0] above;
  logic        rnd;
  logic [52:0] kept;
  logic [52:0] lead_sh;
  logic [10:0] efield;
  logic [10:0] mag;
  logic [18:0] mprod;
  logic [6:0]  q1;
  logic [10:0] q1x10;

  always_comb begin
    p       = (precision > dthf_pkg::FRAC_NIBBLES) ? dthf_pkg::FRAC_NIBBLES : precision;
    mant    = {1'b1, a_bits[51:0]};
    sh      = {dthf_pkg::FRAC_NIBBLES - p, 2'b00};
    kept0   = mant >> sh;
    above   = mant >> (sh - 6'd1);
    rnd     = (sh != 6'd0) && above[0];
    kept    = kept0 + {52'd0, rnd};
    lead_sh = kept >> {p, 2'b00};
    efield  = a_bits[62:52];
    mag     = (efield < dthf_pkg::EXP_BIAS) ? (dthf_pkg::EXP_BIAS - efield)
                                            : (efield - dthf_pkg::EXP_BIAS);
    mprod   = {8'd0, mag} * {11'd0, dthf_pkg::RECIP10};
    q1      = mprod[17:11];
    q1x10   = {1'b0, q1, 3'b000} + {3'b000, q1, 1'b0};
    rec_next.neg  = a_bits[63];
    rec_next.prec = p;
    rec_next.lead = lead_sh[3:0];
    rec_next.frac = kept[51:0];
    rec_next.eneg = (efield < dthf_pkg::EXP_BIAS);
    rec_next.q1   = q1;
    rec_next.r0   = 4'(mag - q1x10);
  end

  // Character select
  logic [14:0] q2prod;
  logic [3:0]  q2;
  logic [6:0]  q2x10;
  logic [3:0]  r1;
  logic [3:0]  d2;
  logic        d3;
  logic [2:0]  ndig;
  logic [4:0]  j;
  logic [4:0]  base;
  logic [4:0]  nib_idx;
  logic [51:0] frac_sh;
  logic [4:0]  dig_sel;
  logic [3:0]  dig;

  always_comb begin
    q2prod  = {8'd0, b_rec.q1} * {7'd0, dthf_pkg::RECIP10};
    q2      = q2prod[14:11];
    q2x10   = {q2[3:0], 3'b000} + {2'b00, q2, 1'b0};
    r1      = 4'(b_rec.q1 - q2x10);
    d3      = (q2 >= 4'd10);
    d2      = d3 ? (q2 - 4'd10) : q2;
    if (b_rec.q1 >= 7'd100) ndig = 3'd4;
    else if (b_rec.q1 >= 7'd10) ndig = 3'd3;
    else if (b_rec.q1 != 7'd0) ndig = 3'd2;
    else ndig = 3'd1;
    j       = b_idx - {4'd0, b_rec.neg};
    base    = (b_rec.prec != 4'd0) ? (5'd4 + {1'b0, b_rec.prec}) : 5'd3;
    nib_idx = {1'b0, b_rec.prec} + 5'd3 - j;
    frac_sh = b_rec.frac >> {nib_idx[3:0], 2'b00};
    dig_sel = {2'b00, ndig} + base + 5'd1 - j;
    case (dig_sel[1:0])
      2'd0:    dig = b_rec.r0;
      2'd1:    dig = r1;
      2'd2:    dig = d2;
      default: dig = {3'd0, d3};
    endcase
    ch_last = (j == base + 5'd1 + {2'b00, ndig});
    if (b_rec.neg && b_idx == 5'd0) ch = dthf_pkg::CH_MINUS;
    else if (j == 5'd0) ch = dthf_pkg::CH_ZERO;
    else if (j == 5'd1) ch = dthf_pkg::CH_X;
    else if (j == 5'd2) ch = dthf_pkg::hex_char(b_rec.lead);
    else if (b_rec.prec != 4'd0 && j == 5'd3) ch = dthf_pkg::CH_DOT;
    else if (j < base) ch = dthf_pkg::hex_char(frac_sh[3:0]);
    else if (j == base) ch = dthf_pkg::CH_P;
    else if (j == base + 5'd1) ch = b_rec.eneg ? dthf_pkg::CH_MINUS : dthf_pkg::CH_PLUS;
    else ch = dthf_pkg::CH_ZERO + {4'd0, dig};
  end

  assign emit     = b_valid && (!out_valid || out_ready);
  assign a_take   = a_valid && (!b_valid || (emit && ch_last));
  assign in_ready = !a_valid || a_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      precision <= dthf_pkg::PREC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      precision <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
      a_bits  <= value_bits;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_idx   <= 5'd0;
    end else begin
      if (emit) begin
        b_idx <= ch_last ? 5'd0 : b_idx + 5'd1;
      end
      if (a_take) begin
        b_valid <= 1'b1;
        b_rec   <= rec_next;
      end else if (emit && ch_last) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      char_code <= ch;
      last      <= ch_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_IMPL(a_idx_range, b_valid, b_idx <= dthf_pkg::MAX_CHAR_IDX, "char index overrun")
  `ASSERT_NEXT(a_idx_wrap, emit && ch_last, b_idx == 5'd0, "index not cleared after last")
  `ASSERT_IMPL(a_in_room, in_valid && in_ready, !a_valid || a_take, "input register overwritten")
  `ASSERT_NEXT(a_load_start, a_take, b_valid && b_idx == 5'd0, "record loaded mid-text")

endmodule

`default_nettype wire
